FILE: rtl/arpeggiator_note_selector_defines.svh
// Assertion macros for the arpeggiator note selector.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef ARPEGGIATOR_NOTE_SELECTOR_DEFINES_SVH
`define ARPEGGIATOR_NOTE_SELECTOR_DEFINES_SVH

// Check that holds on every edge outside reset
`define ARPNS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that also holds while reset is applied
`define ARPNS_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/arpns_pkg.sv
// Shared constants, command/status types and helper functions for the
// arpeggiator note selector. No dependencies.
package arpns_pkg;

	localparam int HELD_DEPTH = 16;
	localparam int SET_DEPTH  = 32;
	localparam int HIDX_W = $clog2(HELD_DEPTH);
	localparam int HCNT_W = $clog2(HELD_DEPTH + 1);
	localparam int SIDX_W = $clog2(SET_DEPTH);
	localparam int SCNT_W = $clog2(SET_DEPTH + 1);
	localparam int CNT_W  = (HCNT_W > SCNT_W) ? HCNT_W : SCNT_W;
	localparam int DIV_W  = SCNT_W + 8;

	localparam int NOTE_W  = 7;
	localparam int SIZE_W  = 6;
	localparam int KIND_W  = 2;
	localparam int AMODE_W = 3;
	localparam int ROOT_W  = 4;
	localparam int CTYPE_W = 3;
	localparam int SEED_W  = 16;
	localparam int CIDX_W  = 2;

	localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;
	localparam logic [SEED_W-1:0] SEED_RESET = 16'd44257;
	localparam logic [ROOT_W-1:0] ROOT_NONE  = 4'd12;
	localparam logic [CTYPE_W-1:0] CTYPE_NONE = 3'd5;

	// Markov thresholds on the random byte
	localparam logic [7:0] MK_FWD1 = 8'd102;
	localparam logic [7:0] MK_BACK = 8'd153;
	localparam logic [7:0] MK_HOLD = 8'd192;
	localparam logic [7:0] MK_FWD2 = 8'd230;

	// Selection modes
	localparam logic [AMODE_W-1:0] ARP_UP     = 3'd0;
	localparam logic [AMODE_W-1:0] ARP_DOWN   = 3'd1;
	localparam logic [AMODE_W-1:0] ARP_UPDOWN = 3'd2;
	localparam logic [AMODE_W-1:0] ARP_RANDOM = 3'd3;
	localparam logic [AMODE_W-1:0] ARP_SMART  = 3'd4;

	// Input item kinds
	localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STEP    = 2'd2;

	// Register indexes
	localparam logic [CIDX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_ROOT = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_TYPE = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_SEED = 2'd3;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_SCAN_NEXT, OP_PRESS_ADD, OP_REL_HIT, OP_REL_SHIFT,
		OP_REL_DROP, OP_REB_INIT, OP_COPY, OP_COPY_END, OP_TONE_CAND,
		OP_TONE_SCAN_NEXT, OP_TONE_ADD, OP_TONE_SKIP, OP_SORT_LOAD,
		OP_SORT_SHIFT, OP_SORT_PLACE, OP_FIX, OP_PICK, OP_DIV_STEP, OP_EMIT
	} op_t;

	typedef enum logic [1:0] {RD_IDX, RD_JDX, RD_JDXM1, RD_POS} rd_sel_t;

	typedef struct packed {
		op_t     op;
		rd_sel_t rd_sel;
	} cmd_t;

	typedef struct packed {
		logic held_zero;
		logic dirty;
		logic scan_end;
		logic held_match;
		logic held_full;
		logic copy_end;
		logic smart;
		logic tone_end;
		logic cand_high;
		logic set_scan_end;
		logic set_match;
		logic sort_end;
		logic sort_stop;
		logic pick_div;
		logic div_last;
		logic out_free;
		logic [HCNT_W-1:0] held_cnt;
		logic [SCNT_W-1:0] arp_cnt;
		logic [SIDX_W-1:0] cursor;
	} sts_t;

	function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] x);
		lfsr_step = (x >> 1) ^ (x[0] ? LFSR_TAPS : '0);
	endfunction

	// Remainder by twelve for values below 192
	function automatic logic [3:0] mod12(input logic [7:0] x);
		logic [7:0] r;
		r = x;
		if (r >= 8'd96) r = r - 8'd96;
		if (r >= 8'd48) r = r - 8'd48;
		if (r >= 8'd24) r = r - 8'd24;
		if (r >= 8'd12) r = r - 8'd12;
		mod12 = r[3:0];
	endfunction

	function automatic logic [2:0] tone_count(input logic [CTYPE_W-1:0] ct);
		tone_count = (ct < 3'd2) ? 3'd3 : 3'd4;
	endfunction

	function automatic logic [3:0] tone_step(input logic [CTYPE_W-1:0] ct,
		input logic [1:0] t);
		logic [3:0] s;
		s = 4'd0;
		case (t)
			2'd1: s = (ct == 3'd1 || ct == 3'd3) ? 4'd3 : 4'd4;
			2'd2: s = 4'd7;
			2'd3: s = (ct == 3'd4) ? 4'd11 : 4'd10;
			default: s = 4'd0;
		endcase
		tone_step = s;
	endfunction

endpackage

FILE: rtl/arpeggiator_note_selector.sv
// Top level of the arpeggiator note selector: sequencer plus datapath.
// Depends on arpns_pkg, arpns_ctrl, arpns_dp and the assertion macro header.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------
//  input   | in_valid / in_stall  | mode, note
//  result  | out_valid / out_stall| note_out, set_size
//  config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Press and release scan the held list, one entry per cycle. A step on a
// clean set picks and emits; a random draw adds a restoring remainder loop;
// a rebuild adds copy, chord-tone scan and an insertion sort with one
// set-memory access per cycle.
// Reset clears all counters and flags at once; no clearing pass.
// in_stall is high from acceptance until the result is loaded in the output
// register; a stalled result holds while the next item is taken.
`include "arpeggiator_note_selector_defines.svh"

module arpeggiator_note_selector import arpns_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [KIND_W-1:0]  mode,
	input  logic [NOTE_W-1:0]  note,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [NOTE_W-1:0]  note_out,
	output logic [SIZE_W-1:0]  set_size,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [SEED_W-1:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;

	arpns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	arpns_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.note      (note),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.note_out  (note_out),
		.set_size  (set_size)
	);

	// Checks
	`ARPNS_ASSERT(a_held_bound, sts.held_cnt <= HCNT_W'(HELD_DEPTH), "held count overflow")
	`ARPNS_ASSERT(a_size_nonzero, $rose(out_valid) |-> set_size != '0, "empty set emitted")
	`ARPNS_ASSERT(a_cursor_range, (!in_stall && sts.arp_cnt != '0) |-> SCNT_W'(sts.cursor) < sts.arp_cnt, "cursor out of range")
	`ARPNS_ASSERT_RST(a_reset_quiet, !arst_n |-> !out_valid, "result during reset")

endmodule

FILE: rtl/arpns_ctrl.sv
// Sequencer for the arpeggiator note selector: walks press, release,
// rebuild, sort and pick phases. Depends on arpns_pkg.
module arpns_ctrl import arpns_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] mode,
	output logic              in_stall,
	input  sts_t              sts,
	output cmd_t              cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_PRESS, S_REL, S_REL_SHIFT, S_REB, S_COPY, S_TONE_CAND,
		S_TONE_SCAN, S_SORT_OUTER, S_SORT_INNER, S_FIX, S_PICK, S_DIV, S_EMIT
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	// Next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		unique case (state_q)
			S_SORT_OUTER: cmd.rd_sel = RD_IDX;
			S_SORT_INNER: cmd.rd_sel = RD_JDXM1;
			S_EMIT:       cmd.rd_sel = RD_POS;
			default:      cmd.rd_sel = RD_JDX;
		endcase
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					case (mode)
						KIND_PRESS:   state_d = S_PRESS;
						KIND_RELEASE: state_d = S_REL;
						KIND_STEP: begin
							if (sts.held_zero) state_d = S_IDLE;
							else if (sts.dirty) state_d = S_REB;
							else state_d = S_PICK;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_PRESS: begin
				if (sts.scan_end) begin
					if (!sts.held_full) cmd.op = OP_PRESS_ADD;
					state_d = S_IDLE;
				end else if (sts.held_match) begin
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_SCAN_NEXT;
				end
			end
			S_REL: begin
				if (sts.scan_end) begin
					state_d = S_IDLE;
				end else if (sts.held_match) begin
					cmd.op = OP_REL_HIT;
					state_d = S_REL_SHIFT;
				end else begin
					cmd.op = OP_SCAN_NEXT;
				end
			end
			S_REL_SHIFT: begin
				if (sts.scan_end) begin
					cmd.op = OP_REL_DROP;
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_REL_SHIFT;
				end
			end
			S_REB: begin
				cmd.op = OP_REB_INIT;
				state_d = S_COPY;
			end
			S_COPY: begin
				if (sts.copy_end) begin
					cmd.op = OP_COPY_END;
					state_d = sts.smart ? S_TONE_CAND : S_SORT_OUTER;
				end else begin
					cmd.op = OP_COPY;
				end
			end
			S_TONE_CAND: begin
				if (sts.tone_end) begin
					state_d = S_SORT_OUTER;
				end else begin
					cmd.op = OP_TONE_CAND;
					state_d = S_TONE_SCAN;
				end
			end
			S_TONE_SCAN: begin
				if (sts.cand_high) begin
					cmd.op = OP_TONE_SKIP;
					state_d = S_TONE_CAND;
				end else if (sts.set_scan_end) begin
					cmd.op = OP_TONE_ADD;
					state_d = S_TONE_CAND;
				end else if (sts.set_match) begin
					cmd.op = OP_TONE_SKIP;
					state_d = S_TONE_CAND;
				end else begin
					cmd.op = OP_TONE_SCAN_NEXT;
				end
			end
			S_SORT_OUTER: begin
				if (sts.sort_end) begin
					state_d = S_FIX;
				end else begin
					cmd.op = OP_SORT_LOAD;
					state_d = S_SORT_INNER;
				end
			end
			S_SORT_INNER: begin
				if (sts.sort_stop) begin
					cmd.op = OP_SORT_PLACE;
					state_d = S_SORT_OUTER;
				end else begin
					cmd.op = OP_SORT_SHIFT;
				end
			end
			S_FIX: begin
				cmd.op = OP_FIX;
				state_d = S_PICK;
			end
			S_PICK: begin
				cmd.op = OP_PICK;
				state_d = sts.pick_div ? S_DIV : S_EMIT;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (sts.div_last) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.op = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/arpns_dp.sv
// Datapath of the arpeggiator note selector: held list, arpeggio set,
// cursors, LFSR, remainder unit and output register. Depends on arpns_pkg.
module arpns_dp import arpns_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [SEED_W-1:0]  cfg_data,
	input  logic [NOTE_W-1:0]  note,
	input  logic               out_stall,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic               out_valid,
	output logic [NOTE_W-1:0]  note_out,
	output logic [SIZE_W-1:0]  set_size
);

	logic [NOTE_W-1:0]  held_q [HELD_DEPTH];
	logic [NOTE_W-1:0]  set_q [SET_DEPTH];
	logic [HCNT_W-1:0]  held_total_q;
	logic [SCNT_W-1:0]  arp_total_q;
	logic [SIDX_W-1:0]  cursor_q, chain_q, pos_q;
	logic               asc_q, dirty_q, half_q, div_chain_q, out_valid_q;
	logic [SEED_W-1:0]  lfsr_q;
	logic [AMODE_W-1:0] amode_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CTYPE_W-1:0] ctype_q;
	logic [NOTE_W-1:0]  key_q, val_q, lowest_q, note_out_q;
	logic [CNT_W-1:0]   idx_q;
	logic [SCNT_W-1:0]  jdx_q;
	logic [2:0]         tone_q, dstep_q;
	logic [7:0]         cand_q, rem_q;
	logic [SIZE_W-1:0]  size_q;

	logic [NOTE_W-1:0]  held_rd, set_rd;
	logic [SCNT_W-1:0]  set_addr;
	logic               cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign out_valid = out_valid_q;
	assign note_out  = note_out_q;
	assign set_size  = size_q;

	// Single read port on each store
	assign held_rd = held_q[idx_q[HIDX_W-1:0]];
	always_comb begin
		case (cmd.rd_sel)
			RD_IDX:   set_addr = SCNT_W'(idx_q);
			RD_JDXM1: set_addr = jdx_q - 1'b1;
			RD_POS:   set_addr = SCNT_W'(pos_q);
			default:  set_addr = jdx_q;
		endcase
	end
	assign set_rd = set_q[set_addr[SIDX_W-1:0]];

	// Chord tone candidate
	logic [4:0] pc_sum;
	logic [3:0] pc, lmod, diff;
	logic [7:0] cand_d;
	always_comb begin
		pc_sum = {1'b0, root_q} + {1'b0, tone_step(ctype_q, tone_q[1:0])};
		pc = (pc_sum >= 5'd12) ? 4'(pc_sum - 5'd12) : pc_sum[3:0];
		lmod = mod12({1'b0, lowest_q});
		diff = (pc >= lmod) ? (pc - lmod) : (pc + 4'd12 - lmod);
		cand_d = {1'b0, lowest_q} + {4'd0, diff} + (half_q ? 8'd12 : 8'd0);
	end

	// Pick arithmetic
	logic [SEED_W-1:0] lfsr1, lfsr2;
	logic [7:0]        r1;
	logic [SCNT_W-1:0] n, c, ch, cc, p1, pm, p2;
	logic              markov;
	always_comb begin
		lfsr1 = lfsr_step(lfsr_q);
		lfsr2 = lfsr_step(lfsr1);
		r1 = lfsr1[7:0];
		n  = arp_total_q;
		c  = SCNT_W'(cursor_q);
		ch = SCNT_W'(chain_q);
		cc = (c >= n) ? n - 1'b1 : c;
		p1 = (ch + 1'b1 == n) ? '0 : ch + 1'b1;
		pm = (ch == '0) ? n - 1'b1 : ch - 1'b1;
		p2 = ch + SCNT_W'(2);
		if (p2 >= n) p2 = p2 - n;
		if (p2 >= n) p2 = p2 - n;
		markov = !(amode_q == ARP_UP || amode_q == ARP_DOWN ||
			amode_q == ARP_UPDOWN || amode_q == ARP_RANDOM);
	end

	// Restoring remainder step
	logic [DIV_W-1:0] dsh;
	logic [7:0]       rem_d;
	always_comb begin
		dsh = DIV_W'(n) << dstep_q;
		rem_d = (DIV_W'(rem_q) >= dsh) ? rem_q - dsh[7:0] : rem_q;
	end

	// Status toward the sequencer
	always_comb begin
		sts.held_zero    = (held_total_q == '0);
		sts.dirty        = dirty_q;
		sts.scan_end     = (idx_q >= CNT_W'(held_total_q));
		sts.held_match   = (held_rd == key_q);
		sts.held_full    = (held_total_q == HCNT_W'(HELD_DEPTH));
		sts.copy_end     = sts.scan_end || (arp_total_q == SCNT_W'(SET_DEPTH));
		sts.smart        = (amode_q == ARP_SMART) && (root_q < ROOT_NONE) &&
			(ctype_q < CTYPE_NONE);
		sts.tone_end     = (tone_q >= tone_count(ctype_q));
		sts.cand_high    = cand_q[7];
		sts.set_scan_end = (jdx_q == arp_total_q);
		sts.set_match    = (set_rd == cand_q[6:0]);
		sts.sort_end     = (idx_q >= CNT_W'(arp_total_q));
		sts.sort_stop    = (jdx_q == '0) || !(set_rd > val_q);
		sts.pick_div     = (amode_q == ARP_RANDOM) || (markov && r1 >= MK_FWD2);
		sts.div_last     = (dstep_q == '0);
		sts.out_free     = !out_valid_q || !out_stall;
		sts.held_cnt     = held_total_q;
		sts.arp_cnt      = arp_total_q;
		sts.cursor       = cursor_q;
	end

	// Stores and scratch registers without reset
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: key_q <= note;
			OP_PRESS_ADD: held_q[held_total_q[HIDX_W-1:0]] <= key_q;
			OP_REL_SHIFT: held_q[HIDX_W'(idx_q - 1'b1)] <= held_rd;
			OP_REB_INIT: lowest_q <= '1;
			OP_COPY: begin
				set_q[arp_total_q[SIDX_W-1:0]] <= held_rd;
				if (held_rd < lowest_q) lowest_q <= held_rd;
			end
			OP_TONE_CAND: cand_q <= cand_d;
			OP_TONE_ADD: begin
				if (arp_total_q < SCNT_W'(SET_DEPTH))
					set_q[arp_total_q[SIDX_W-1:0]] <= cand_q[6:0];
			end
			OP_SORT_LOAD: val_q <= set_rd;
			OP_SORT_SHIFT: set_q[jdx_q[SIDX_W-1:0]] <= set_rd;
			OP_SORT_PLACE: set_q[jdx_q[SIDX_W-1:0]] <= val_q;
			OP_EMIT: begin
				note_out_q <= set_rd;
				size_q <= SIZE_W'(arp_total_q);
			end
			default: ;
		endcase
	end

	// Control state and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amode_q      <= ARP_UP;
			root_q       <= ROOT_NONE;
			ctype_q      <= CTYPE_NONE;
			lfsr_q       <= SEED_RESET;
			held_total_q <= '0;
			arp_total_q  <= '0;
			cursor_q     <= '0;
			chain_q      <= '0;
			pos_q        <= '0;
			asc_q        <= 1'b1;
			dirty_q      <= 1'b0;
			idx_q        <= '0;
			jdx_q        <= '0;
			tone_q       <= '0;
			half_q       <= 1'b0;
			rem_q        <= '0;
			dstep_q      <= '0;
			div_chain_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			// Register writes
			if (cfg_wr) begin
				unique case (cfg_index)
					CFG_MODE: begin
						amode_q <= cfg_data[AMODE_W-1:0];
						dirty_q <= 1'b1;
					end
					CFG_ROOT: begin
						root_q <= cfg_data[ROOT_W-1:0];
						dirty_q <= 1'b1;
					end
					CFG_TYPE: begin
						ctype_q <= cfg_data[CTYPE_W-1:0];
						dirty_q <= 1'b1;
					end
					CFG_SEED: lfsr_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				OP_LOAD: idx_q <= '0;
				OP_SCAN_NEXT: idx_q <= idx_q + 1'b1;
				OP_PRESS_ADD: begin
					held_total_q <= held_total_q + 1'b1;
					dirty_q <= 1'b1;
				end
				OP_REL_HIT: begin
					idx_q <= idx_q + 1'b1;
					dirty_q <= 1'b1;
				end
				OP_REL_SHIFT: idx_q <= idx_q + 1'b1;
				OP_REL_DROP: held_total_q <= held_total_q - 1'b1;
				OP_REB_INIT: begin
					arp_total_q <= '0;
					dirty_q <= 1'b0;
					idx_q <= '0;
				end
				OP_COPY: begin
					arp_total_q <= arp_total_q + 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				OP_COPY_END: begin
					idx_q <= CNT_W'(1);
					tone_q <= '0;
					half_q <= 1'b0;
				end
				OP_TONE_CAND: jdx_q <= '0;
				OP_TONE_SCAN_NEXT: jdx_q <= jdx_q + 1'b1;
				OP_TONE_ADD, OP_TONE_SKIP: begin
					if (cmd.op == OP_TONE_ADD && arp_total_q < SCNT_W'(SET_DEPTH))
						arp_total_q <= arp_total_q + 1'b1;
					half_q <= !half_q;
					if (half_q) tone_q <= tone_q + 1'b1;
				end
				OP_SORT_LOAD: jdx_q <= SCNT_W'(idx_q);
				OP_SORT_SHIFT: jdx_q <= jdx_q - 1'b1;
				OP_SORT_PLACE: idx_q <= idx_q + 1'b1;
				OP_FIX: begin
					if (c >= n) cursor_q <= '0;
					if (ch >= n) chain_q <= '0;
				end
				OP_PICK: begin
					case (amode_q)
						ARP_UP, ARP_DOWN: begin
							pos_q <= (amode_q == ARP_UP) ? cursor_q
								: SIDX_W'(n - 1'b1 - c);
							cursor_q <= (c + 1'b1 == n) ? '0 : SIDX_W'(c + 1'b1);
						end
						ARP_UPDOWN: begin
							if (n == SCNT_W'(1)) begin
								pos_q <= '0;
							end else begin
								pos_q <= SIDX_W'(cc);
								if (asc_q) begin
									if (cc >= n - 1'b1) begin
										asc_q <= 1'b0;
										cursor_q <= SIDX_W'(cc - 1'b1);
									end else begin
										cursor_q <= SIDX_W'(cc + 1'b1);
									end
								end else if (cc == '0) begin
									asc_q <= 1'b1;
									cursor_q <= SIDX_W'(1);
								end else begin
									cursor_q <= SIDX_W'(cc - 1'b1);
								end
							end
						end
						ARP_RANDOM: begin
							lfsr_q <= lfsr1;
							rem_q <= r1;
							dstep_q <= 3'd7;
							div_chain_q <= 1'b0;
						end
						default: begin
							if (r1 < MK_FWD1) begin
								lfsr_q <= lfsr1;
								pos_q <= SIDX_W'(p1);
								chain_q <= SIDX_W'(p1);
							end else if (r1 < MK_BACK) begin
								lfsr_q <= lfsr1;
								pos_q <= SIDX_W'(pm);
								chain_q <= SIDX_W'(pm);
							end else if (r1 < MK_HOLD) begin
								lfsr_q <= lfsr1;
								pos_q <= chain_q;
							end else if (r1 < MK_FWD2) begin
								lfsr_q <= lfsr1;
								pos_q <= SIDX_W'(p2);
								chain_q <= SIDX_W'(p2);
							end else begin
								lfsr_q <= lfsr2;
								rem_q <= lfsr2[7:0];
								dstep_q <= 3'd7;
								div_chain_q <= 1'b1;
							end
						end
					endcase
				end
				OP_DIV_STEP: begin
					rem_q <= rem_d;
					dstep_q <= dstep_q - 1'b1;
					if (dstep_q == '0) begin
						pos_q <= SIDX_W'(rem_d);
						if (div_chain_q) chain_q <= SIDX_W'(rem_d);
					end
				end
				OP_EMIT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

endmodule
